// ----- rtl/core/mqfm_pkg.sv -----
package mqfm_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned QIDX_W  = 4;
  localparam int unsigned VALUE_W = 32;

  // Default sizing
  localparam int unsigned NUM_QUEUES_DEF = 16;
  localparam int unsigned POOL_DEPTH_DEF = 256;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Operation codes on action_i
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Free-list commands from the sequencer
  typedef struct packed {
    logic alloc;      // take the entry at the free head
    logic give_back;  // push an entry back on the free head
  } free_cmd_t;

endpackage

// ----- rtl/core/multi_queue_fifo_manager.sv -----
// Channel   Handshake                 Payload
// command   start_i / busy_o          action_i, queue_index_i, data_value_i
// result    done_o (one-cycle strobe) out_value_o, queue_was_empty_o, pool_full_o
//
// An enqueue passes through ST_ENQ, a dequeue through ST_DEQ_RD and ST_DEQ_WR; a rejected
// command (bad queue, empty queue, exhausted pool) is answered from idle. The registered
// read ports of the queue table and entry memories set this: a dequeue reads its head
// pointer, then the entry it points at, then writes back. The registered result strobe
// follows in the cycle after the last step. Reset empties every queue at once; entries
// never used yet are tracked by a watermark, so no clearing pass. Results cannot be held off.
module multi_queue_fifo_manager #(
  parameter int unsigned NUM_QUEUES = mqfm_pkg::NUM_QUEUES_DEF,
  parameter int unsigned POOL_DEPTH = mqfm_pkg::POOL_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = mqfm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                action_i,
  input  logic        [mqfm_pkg::QIDX_W-1:0]  queue_index_i,
  input  logic signed [mqfm_pkg::VALUE_W-1:0] data_value_i,
  output logic                                done_o,
  output logic signed [mqfm_pkg::VALUE_W-1:0] out_value_o,
  output logic                                queue_was_empty_o,
  output logic                                pool_full_o
);

  localparam int unsigned PW = $clog2(POOL_DEPTH);
  localparam int unsigned QW = $clog2(NUM_QUEUES);
  localparam int unsigned IW = mqfm_pkg::QIDX_W;
  localparam int unsigned VW = mqfm_pkg::VALUE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENQ,
    ST_DEQ_RD,
    ST_DEQ_WR
  } state_e;

  state_e state_q, state_d;

  logic [QW-1:0]         q_addr_q, q_addr_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  done_q, done_d;
  logic [VW-1:0]         out_value_q, out_value_d;
  logic                  was_empty_q, was_empty_d;
  logic                  pool_full_q, pool_full_d;
  logic [NUM_QUEUES-1:0] nonempty_q, nonempty_d;

  // Queue index decode
  logic [QW+IW-1:0] idx_ext;
  logic [QW-1:0]    q_addr_in;
  logic             q_ok;

  assign idx_ext   = {{QW{1'b0}}, queue_index_i};
  assign q_addr_in = idx_ext[QW-1:0];
  assign q_ok      = (idx_ext < (QW + IW)'(NUM_QUEUES));

  // Memory ports
  logic                  qt_we;
  logic [QW-1:0]         qt_raddr;
  logic [2*PW-1:0]       qt_wdata, qt_rdata;
  logic [PW-1:0]         qt_head, qt_tail;
  logic                  ln_we;
  logic [PW-1:0]         ln_waddr, ln_wdata, ln_raddr, ln_rdata;
  logic                  va_we;
  logic [DATA_WIDTH-1:0] va_rdata;

  assign qt_head = qt_rdata[2*PW-1:PW];
  assign qt_tail = qt_rdata[PW-1:0];

  // Free list
  mqfm_pkg::free_cmd_t free_cmd;
  logic [PW-1:0]       free_head;
  logic                free_empty;

  mqfm_free_ctrl #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_free_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (free_cmd),
    .link_i    (ln_rdata),
    .release_i (qt_head),
    .head_o    (free_head),
    .empty_o   (free_empty)
  );

  // Head and tail pointer per queue
  mqfm_ram #(
    .WIDTH (2 * PW),
    .DEPTH (NUM_QUEUES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (qt_we),
    .waddr_i (q_addr_q),
    .wdata_i (qt_wdata),
    .raddr_i (qt_raddr),
    .rdata_o (qt_rdata)
  );

  // Next-link word per pool entry
  mqfm_ram #(
    .WIDTH (PW),
    .DEPTH (POOL_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .raddr_i (ln_raddr),
    .rdata_o (ln_rdata)
  );

  // Stored value per pool entry
  mqfm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (POOL_DEPTH)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (va_we),
    .waddr_i (free_head),
    .wdata_i (data_q),
    .raddr_i (qt_head),
    .rdata_o (va_rdata)
  );

  // Hold the queue address after accept so the table output stays put
  assign qt_raddr = (state_q == ST_IDLE) ? q_addr_in : q_addr_q;
  // Read the free head's link while idle, the queue head's link on a dequeue
  assign ln_raddr = (state_q == ST_IDLE) ? free_head : qt_head;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    q_addr_d    = q_addr_q;
    data_d      = data_q;
    done_d      = 1'b0;
    out_value_d = '0;
    was_empty_d = 1'b0;
    pool_full_d = 1'b0;
    nonempty_d  = nonempty_q;
    qt_we       = 1'b0;
    qt_wdata    = qt_rdata;
    ln_we       = 1'b0;
    ln_waddr    = qt_tail;
    ln_wdata    = free_head;
    va_we       = 1'b0;
    free_cmd    = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          q_addr_d = q_addr_in;
          data_d   = DATA_WIDTH'($unsigned(data_value_i));
          if (action_i == mqfm_pkg::ACT_ENQ) begin
            if (!q_ok) begin
              done_d = 1'b1;
            end else if (free_empty) begin
              done_d      = 1'b1;
              pool_full_d = 1'b1;
            end else begin
              state_d = ST_ENQ;
            end
          end else begin
            if (!q_ok || !nonempty_q[q_addr_in]) begin
              done_d      = 1'b1;
              was_empty_d = 1'b1;
            end else begin
              state_d = ST_DEQ_RD;
            end
          end
        end
      end

      // Fill the free head entry and link it after the tail
      ST_ENQ: begin
        va_we          = 1'b1;
        ln_we          = nonempty_q[q_addr_q];
        ln_waddr       = qt_tail;
        ln_wdata       = free_head;
        qt_we          = 1'b1;
        qt_wdata       = {nonempty_q[q_addr_q] ? qt_head : free_head, free_head};
        nonempty_d[q_addr_q] = 1'b1;
        free_cmd.alloc = 1'b1;
        done_d         = 1'b1;
        state_d        = ST_IDLE;
      end

      // Wait for the head entry's value and link
      ST_DEQ_RD: begin
        state_d = ST_DEQ_WR;
      end

      // Return the head entry and advance the head, or mark the queue empty if it was the last
      ST_DEQ_WR: begin
        out_value_d = VW'($signed(va_rdata));
        if (qt_head == qt_tail) begin
          nonempty_d[q_addr_q] = 1'b0;
        end else begin
          qt_we    = 1'b1;
          qt_wdata = {ln_rdata, qt_tail};
        end
        ln_we              = 1'b1;
        ln_waddr           = qt_head;
        ln_wdata           = free_head;
        free_cmd.give_back = 1'b1;
        done_d             = 1'b1;
        state_d            = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, captured command and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      nonempty_q  <= '0;
      q_addr_q    <= '0;
      data_q      <= '0;
      out_value_q <= '0;
      was_empty_q <= 1'b0;
      pool_full_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      nonempty_q  <= nonempty_d;
      q_addr_q    <= q_addr_d;
      data_q      <= data_d;
      out_value_q <= out_value_d;
      was_empty_q <= was_empty_d;
      pool_full_q <= pool_full_d;
    end
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign out_value_o       = out_value_q;
  assign queue_was_empty_o = was_empty_q;
  assign pool_full_o       = pool_full_q;

endmodule

// ----- rtl/core/mqfm_ram.sv -----
module mqfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/mqfm_free_ctrl.sv -----
module mqfm_free_ctrl #(
  parameter int unsigned POOL_DEPTH = mqfm_pkg::POOL_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mqfm_pkg::free_cmd_t           cmd_i,
  input  logic [$clog2(POOL_DEPTH)-1:0] link_i,     // link word read at the free head
  input  logic [$clog2(POOL_DEPTH)-1:0] release_i,  // entry handed back
  output logic [$clog2(POOL_DEPTH)-1:0] head_o,
  output logic                          empty_o
);

  localparam int unsigned PW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

  logic [PW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] mark_q, mark_d;   // entries below the mark have had their link written
  logic          fresh;
  logic [PW-1:0] fresh_next;

  // An entry at or above the mark still carries its reset chain to the next entry
  assign fresh      = (CW'(head_q) >= mark_q);
  assign fresh_next = (head_q == PW'(POOL_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // Pop or push the free head
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    mark_d  = mark_q;
    if (cmd_i.alloc) begin
      head_d  = fresh ? fresh_next : link_i;
      count_d = count_q - 1'b1;
      if (fresh) begin
        mark_d = mark_q + 1'b1;
      end
    end else if (cmd_i.give_back) begin
      head_d = release_i;
      if (count_q < CW'(POOL_DEPTH)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= CW'(POOL_DEPTH);
      mark_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      mark_q  <= mark_d;
    end
  end

  assign head_o  = head_q;
  assign empty_o = (count_q == '0);

endmodule
